@@ src/spa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment placement allocator package
// Shared constants, entry and control types for the allocator and its cells.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int unsigned MAX_SEGMENTS = 32;
  localparam int unsigned ADDR_BITS    = 20;
  localparam int unsigned LEN_W        = 21;
  localparam int unsigned KIND_W       = 2;
  localparam int unsigned ID_W         = 16;
  localparam int unsigned CMD_W        = 2;
  localparam int unsigned STAT_W       = 3;
  localparam int unsigned SLOT_W       = $clog2(MAX_SEGMENTS);
  localparam int unsigned END_W        = ((ADDR_BITS > LEN_W) ? ADDR_BITS : LEN_W) + 1;

  localparam int unsigned IN_FIELDS_W  = KIND_W + ID_W + LEN_W;
  localparam int unsigned IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = 2 * ADDR_BITS + LEN_W + KIND_W + ID_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [LEN_W-1:0] MEM_SIZE_RESET = LEN_W'(4096);

  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_COMPACT = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_NOSPACE  = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_MOVE     = 3'd4
  } stat_e;

  typedef enum logic {
    FIT_FF = 1'b0,
    FIT_BF = 1'b1
  } fit_e;

  typedef enum logic {
    REG_MEMORY_SIZE = 1'b0,
    REG_FIT_MODE    = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_WALK   = 3'b010,
    S_FINISH = 3'b100
  } state_e;

  typedef enum logic [1:0] {
    SEL_HOLD = 2'd0,
    SEL_NEXT = 2'd1,
    SEL_PREV = 2'd2,
    SEL_LOAD = 2'd3
  } cell_sel_e;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [LEN_W-1:0]     length;
    logic [KIND_W-1:0]    kind;
    logic [ID_W-1:0]      owner;
    slot_t                slot;
  } seg_t;

  typedef struct packed {
    logic above;
    logic hit;
  } cell_flags_t;

  typedef struct packed {
    stat_e                status;
    logic [ADDR_BITS-1:0] address;
    logic [ADDR_BITS-1:0] old_address;
    logic [LEN_W-1:0]     moved_length;
    logic [KIND_W-1:0]    moved_kind;
    logic [ID_W-1:0]      moved_id;
    logic                 last;
  } result_t;

endpackage

@@ src/spa_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment table cell
// Holds one table entry and takes its neighbour's, a new entry or its own.
// ----------------------------------------------------------------------------
module spa_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  spa_pkg::cell_sel_e             sel_i,
  input  logic                           prev_valid_i,
  input  spa_pkg::seg_t                  prev_seg_i,
  input  logic                           next_valid_i,
  input  spa_pkg::seg_t                  next_seg_i,
  input  spa_pkg::seg_t                  new_seg_i,
  input  logic [spa_pkg::ADDR_BITS-1:0]  key_addr_i,
  input  spa_pkg::slot_t                 key_slot_i,
  output logic                           valid_o,
  output spa_pkg::seg_t                  seg_o,
  output spa_pkg::cell_flags_t           flags_o
);

  logic          valid_q, valid_d;
  spa_pkg::seg_t seg_q, seg_d;

  always_comb begin
    valid_d = valid_q;
    seg_d   = seg_q;
    unique case (sel_i)
      spa_pkg::SEL_HOLD: begin
        valid_d = valid_q;
      end
      spa_pkg::SEL_NEXT: begin
        valid_d = next_valid_i;
        seg_d   = next_seg_i;
      end
      spa_pkg::SEL_PREV: begin
        valid_d = prev_valid_i;
        seg_d   = prev_seg_i;
      end
      spa_pkg::SEL_LOAD: begin
        valid_d = 1'b1;
        seg_d   = new_seg_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seg_q <= seg_d;
  end

  assign valid_o       = valid_q;
  assign seg_o         = seg_q;
  assign flags_o.above = valid_q && (seg_q.start > key_addr_i);
  assign flags_o.hit   = valid_q && (seg_q.slot == key_slot_i);

endmodule

@@ src/segment_placement_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment placement allocator
// Keeps a table of segments sorted by start in a row of cells and serves
// allocate, release and compact commands over it.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         tuser: command; tdata: seg_kind, element_id, length
// m_axis    out        tuser: status; tdata: address, old_address,
//                      moved_length, moved_kind, moved_id; tlast: last
// cfg       in         index 0 memory_size, index 1 fit_mode
//
// An allocate, release or compact is accepted in S_IDLE; in S_WALK the table
// rotates once past the head of the row, one cell per step, and S_FINISH
// inserts or removes an entry and issues the closing result of an allocate
// or release. A new command is accepted only once the block is back in S_IDLE.
// An allocate of zero length or into a full table skips the rotation and goes
// straight to S_FINISH; a CMD_NONE is accepted and leaves the block in S_IDLE.
// A compact issues one move record as each valid entry passes the head and
// stalls that step while the output register is still full; the closing
// result of an allocate or release waits in the same way.
// Reset empties the table at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module segment_placement_allocator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata: seg_kind, element_id, length, zero pad
  input  logic [spa_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // tuser: command
  input  logic [spa_pkg::CMD_W-1:0]         s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // tdata: address, old_address, moved_length, moved_kind, moved_id, zero pad
  output logic [spa_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  // tuser: status
  output logic [spa_pkg::STAT_W-1:0]        m_axis_tuser_o,
  output logic                              m_axis_tlast_o,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [spa_pkg::LEN_W-1:0]         cfg_data_i
);

  localparam int unsigned N = spa_pkg::MAX_SEGMENTS;
  localparam int unsigned AW = spa_pkg::ADDR_BITS;
  localparam int unsigned EW = spa_pkg::END_W;

  // Configuration
  logic [spa_pkg::LEN_W-1:0] mem_size_q;
  spa_pkg::fit_e             fit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_size_q <= spa_pkg::MEM_SIZE_RESET;
      fit_q      <= spa_pkg::FIT_FF;
    end else if (cfg_we_i) begin
      unique case (spa_pkg::reg_idx_e'(cfg_idx_i))
        spa_pkg::REG_MEMORY_SIZE: mem_size_q <= cfg_data_i;
        spa_pkg::REG_FIT_MODE:    fit_q      <= spa_pkg::fit_e'(cfg_data_i[0]);
      endcase
    end
  end

  logic [EW-1:0] mem_lim;
  assign mem_lim = (EW'(mem_size_q) > (EW'(1) << AW)) ? (EW'(1) << AW) : EW'(mem_size_q);

  // Cell row
  logic                  valid_vec [N];
  logic [N-1:0]          valid_bits;
  spa_pkg::seg_t         seg_arr   [N];
  spa_pkg::cell_flags_t  flags_arr [N];
  spa_pkg::cell_sel_e    sel_arr   [N];
  logic                  wrap_valid;
  spa_pkg::seg_t         wrap_seg;
  spa_pkg::seg_t         new_seg;

  // Control
  spa_pkg::state_e        state_q, state_d;
  spa_pkg::cmd_e          cmd_q;
  logic [spa_pkg::KIND_W-1:0] kind_q;
  logic [spa_pkg::ID_W-1:0]   id_q;
  logic [spa_pkg::LEN_W-1:0]  len_q;
  spa_pkg::stat_e         rej_q;
  logic [spa_pkg::SLOT_W-1:0] step_q;
  spa_pkg::slot_t         free_slot_q, free_slot;
  logic                   found_q, found_d;
  logic [EW-1:0]          best_gap_q, best_gap_d;
  logic [EW-1:0]          best_addr_q, best_addr_d;
  logic [EW-1:0]          prev_end_q, prev_end_d;
  logic                   tail_done_q, tail_done_d;
  logic                   hit_q, hit_d;
  spa_pkg::slot_t         hit_slot_q, hit_slot_d;
  logic [EW-1:0]          next_q, next_d;
  logic [N-1:0]           used_q, used_d;

  logic                   in_acc;
  logic                   out_free;
  logic                   advance;
  logic                   rotate;
  logic                   do_insert;
  logic                   do_remove;
  logic                   out_load;
  spa_pkg::result_t       out_d, out_q;
  logic                   out_valid_q;

  logic [EW-1:0]          seg_s, seg_e, gap;
  logic                   use_it;
  logic [AW-1:0]          nw;

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == spa_pkg::S_IDLE);
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance = !((cmd_q == spa_pkg::CMD_COMPACT) && valid_vec[0] && !out_free);
  assign rotate          = (state_q == spa_pkg::S_WALK) && advance;
  assign nw              = next_q[AW-1:0];

  always_comb begin
    free_slot = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_slot = spa_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    wrap_valid = valid_vec[0];
    wrap_seg   = seg_arr[0];
    if (cmd_q == spa_pkg::CMD_COMPACT) begin
      wrap_seg.start = nw;
    end
    new_seg.start  = best_addr_q[AW-1:0];
    new_seg.length = len_q;
    new_seg.kind   = kind_q;
    new_seg.owner  = id_q;
    new_seg.slot   = free_slot_q;
  end

  // Head-of-row evaluation during the walk
  always_comb begin
    use_it = valid_vec[0] || !tail_done_q;
    seg_s  = valid_vec[0] ? EW'(seg_arr[0].start) : mem_lim;
    seg_e  = valid_vec[0] ? EW'(seg_arr[0].start) + EW'(seg_arr[0].length) : mem_lim;
    gap    = (seg_s > prev_end_q) ? seg_s - prev_end_q : '0;
  end

  always_comb begin
    state_d     = state_q;
    found_d     = found_q;
    best_gap_d  = best_gap_q;
    best_addr_d = best_addr_q;
    prev_end_d  = prev_end_q;
    tail_done_d = tail_done_q;
    hit_d       = hit_q;
    hit_slot_d  = hit_slot_q;
    next_d      = next_q;
    used_d      = used_q;
    do_insert   = 1'b0;
    do_remove   = 1'b0;
    out_load    = 1'b0;
    out_d       = '0;
    out_d.status = spa_pkg::ST_OK;

    unique case (state_q)
      spa_pkg::S_IDLE: begin
        if (in_acc) begin
          found_d     = 1'b0;
          best_gap_d  = '0;
          best_addr_d = '0;
          prev_end_d  = '0;
          tail_done_d = 1'b0;
          hit_d       = 1'b0;
          next_d      = '0;
          unique case (spa_pkg::cmd_e'(s_axis_tuser_i))
            spa_pkg::CMD_ALLOC: begin
              if ((s_axis_tdata_i[38:18] == '0) || (&used_q)) begin
                state_d = spa_pkg::S_FINISH;
              end else begin
                state_d = spa_pkg::S_WALK;
              end
            end
            spa_pkg::CMD_RELEASE, spa_pkg::CMD_COMPACT: begin
              state_d = spa_pkg::S_WALK;
            end
            spa_pkg::CMD_NONE: begin
              state_d = spa_pkg::S_IDLE;
            end
          endcase
        end
      end
      spa_pkg::S_WALK: begin
        if (advance) begin
          if (step_q == spa_pkg::SLOT_W'(N - 1)) begin
            state_d = spa_pkg::S_FINISH;
          end
          case (cmd_q)
            spa_pkg::CMD_ALLOC: begin
              if (use_it) begin
                if (!valid_vec[0]) begin
                  tail_done_d = 1'b1;
                end
                if ((gap >= EW'(len_q)) &&
                    (!found_q || ((fit_q == spa_pkg::FIT_BF) && (gap < best_gap_q)))) begin
                  found_d     = 1'b1;
                  best_gap_d  = gap;
                  best_addr_d = prev_end_q;
                end
                if (seg_e > prev_end_q) begin
                  prev_end_d = seg_e;
                end
              end
            end
            spa_pkg::CMD_RELEASE: begin
              if (valid_vec[0] && (seg_arr[0].kind == kind_q) &&
                  (seg_arr[0].owner == id_q) &&
                  (!hit_q || (seg_arr[0].slot < hit_slot_q))) begin
                hit_d      = 1'b1;
                hit_slot_d = seg_arr[0].slot;
              end
            end
            spa_pkg::CMD_COMPACT: begin
              if (valid_vec[0]) begin
                next_d             = EW'(nw) + EW'(seg_arr[0].length);
                out_load           = 1'b1;
                out_d.status       = spa_pkg::ST_MOVE;
                out_d.address      = nw;
                out_d.old_address  = seg_arr[0].start;
                out_d.moved_length = seg_arr[0].length;
                out_d.moved_kind   = seg_arr[0].kind;
                out_d.moved_id     = seg_arr[0].owner;
                out_d.last = (step_q == spa_pkg::SLOT_W'(N - 1)) || !valid_vec[1];
              end
            end
            default: begin
              next_d = next_q;
            end
          endcase
        end
      end
      spa_pkg::S_FINISH: begin
        if (cmd_q == spa_pkg::CMD_COMPACT) begin
          state_d = spa_pkg::S_IDLE;
        end else if (out_free) begin
          state_d    = spa_pkg::S_IDLE;
          out_load   = 1'b1;
          out_d.last = 1'b1;
          if (cmd_q == spa_pkg::CMD_ALLOC) begin
            if (found_q) begin
              do_insert                = 1'b1;
              used_d[free_slot_q]      = 1'b1;
              out_d.status             = spa_pkg::ST_OK;
              out_d.address            = best_addr_q[AW-1:0];
            end else begin
              out_d.status = rej_q;
            end
          end else begin
            if (hit_q) begin
              do_remove          = 1'b1;
              used_d[hit_slot_q] = 1'b0;
              out_d.status       = spa_pkg::ST_OK;
            end else begin
              out_d.status = spa_pkg::ST_NOTFOUND;
            end
          end
        end
      end
    endcase
  end

  // Per-cell selection: rotate, sorted insert or remove with close-up
  always_comb begin
    logic m_prev;
    logic pre;
    m_prev = 1'b0;
    pre    = 1'b0;
    for (int i = 0; i < N; i++) begin
      sel_arr[i] = spa_pkg::SEL_HOLD;
      pre = pre || flags_arr[i].hit;
      if (rotate) begin
        sel_arr[i] = spa_pkg::SEL_NEXT;
      end else if (do_insert) begin
        if (!valid_vec[i] || flags_arr[i].above) begin
          sel_arr[i] = m_prev ? spa_pkg::SEL_PREV : spa_pkg::SEL_LOAD;
        end
      end else if (do_remove && pre) begin
        sel_arr[i] = spa_pkg::SEL_NEXT;
      end
      m_prev = !valid_vec[i] || flags_arr[i].above;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    spa_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .sel_i        (sel_arr[g]),
      .prev_valid_i ((g == 0) ? 1'b0 : valid_vec[(g == 0) ? 0 : g - 1]),
      .prev_seg_i   (seg_arr[(g == 0) ? 0 : g - 1]),
      .next_valid_i ((g == N - 1) ? (rotate && wrap_valid) : valid_vec[(g == N - 1) ? g : g + 1]),
      .next_seg_i   ((g == N - 1) ? wrap_seg : seg_arr[(g == N - 1) ? g : g + 1]),
      .new_seg_i    (new_seg),
      .key_addr_i   (best_addr_q[AW-1:0]),
      .key_slot_i   (hit_slot_q),
      .valid_o      (valid_vec[g]),
      .seg_o        (seg_arr[g]),
      .flags_o      (flags_arr[g])
    );
    assign valid_bits[g] = valid_vec[g];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spa_pkg::S_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc) begin
        step_q <= '0;
      end else if (rotate) begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    found_q     <= found_d;
    best_gap_q  <= best_gap_d;
    best_addr_q <= best_addr_d;
    prev_end_q  <= prev_end_d;
    tail_done_q <= tail_done_d;
    hit_q       <= hit_d;
    hit_slot_q  <= hit_slot_d;
    next_q      <= next_d;
    if (out_load) begin
      out_q <= out_d;
    end
    if (in_acc) begin
      cmd_q       <= spa_pkg::cmd_e'(s_axis_tuser_i);
      kind_q      <= s_axis_tdata_i[1:0];
      id_q        <= s_axis_tdata_i[17:2];
      len_q       <= s_axis_tdata_i[38:18];
      free_slot_q <= free_slot;
      rej_q       <= ((s_axis_tdata_i[38:18] != '0) && (&used_q)) ?
                     spa_pkg::ST_FULL : spa_pkg::ST_NOSPACE;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tdata_o  = {{(spa_pkg::OUT_DATA_W - spa_pkg::OUT_FIELDS_W){1'b0}},
                            out_q.moved_id, out_q.moved_kind, out_q.moved_length,
                            out_q.old_address, out_q.address};

  a_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == spa_pkg::S_IDLE) |-> ((valid_bits & (valid_bits + 1'b1)) == '0))
    else $error("Valid table entries are not packed at the head of the row.");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == spa_pkg::S_IDLE) |-> ($countones(used_q) == $countones(valid_bits)))
    else $error("Slot usage mask disagrees with the number of valid cells.");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == spa_pkg::S_WALK) && (cmd_q == spa_pkg::CMD_COMPACT) &&
     valid_vec[0] && !out_free) |=> $stable(step_q))
    else $error("Compaction stepped while its move record could not be issued.");

  a_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == spa_pkg::S_FINISH) && (cmd_q == spa_pkg::CMD_ALLOC) && found_q)
    |-> !used_q[free_slot_q])
    else $error("Allocation would reuse a slot that is still in use.");

endmodule

@@ sim/segment_placement_allocator_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment placement allocator checker
// Watches the command and result streams and the register port, keeps its own
// copy of the segment table and compares every result transaction, field by
// field, with the oldest expected one.
// ----------------------------------------------------------------------------
module segment_placement_allocator_checker
  import spa_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  input  logic                   s_axis_tready_i,
  input  logic [IN_DATA_W-1:0]   s_axis_tdata_i,
  input  logic [CMD_W-1:0]       s_axis_tuser_i,
  input  logic                   m_axis_tvalid_i,
  input  logic                   m_axis_tready_i,
  input  logic [OUT_DATA_W-1:0]  m_axis_tdata_i,
  input  logic [STAT_W-1:0]      m_axis_tuser_i,
  input  logic                   m_axis_tlast_i,
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [LEN_W-1:0]       cfg_data_i,
  output int                     errors_o,
  output int                     pending_o,
  output int                     results_o,
  output int                     moves_o
);

  typedef struct {
    bit                 used;
    bit [ADDR_BITS-1:0] start;
    bit [LEN_W-1:0]     length;
    bit [KIND_W-1:0]    kind;
    bit [ID_W-1:0]      owner;
  } slot_rec_t;

  typedef struct {
    bit [STAT_W-1:0]    status;
    bit [ADDR_BITS-1:0] address;
    bit [ADDR_BITS-1:0] old_address;
    bit [LEN_W-1:0]     moved_length;
    bit [KIND_W-1:0]    moved_kind;
    bit [ID_W-1:0]      moved_id;
    bit                 last;
  } outcome_t;

  slot_rec_t  table_q[MAX_SEGMENTS];
  bit [LEN_W-1:0] mem_size;
  bit         best_fit;
  outcome_t   awaited_q[$];

  assign pending_o = awaited_q.size();

  function automatic outcome_t plain(bit [STAT_W-1:0] st, bit [ADDR_BITS-1:0] a);
    outcome_t o;
    o = '{default: 0};
    o.status  = st;
    o.address = a;
    o.last    = 1'b1;
    return o;
  endfunction

  // Valid slots in address order, lower slot first on equal starts.
  function automatic void order_by_start(output int ord[$]);
    int j;
    ord = {};
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      if (table_q[i].used) begin
        j = ord.size();
        while (j > 0 && table_q[ord[j-1]].start > table_q[i].start) j--;
        ord.insert(j, i);
      end
    end
  endfunction

  function automatic void predict_command(bit [CMD_W-1:0] cmd, bit [KIND_W-1:0] kind,
                                          bit [ID_W-1:0] id, bit [LEN_W-1:0] len);
    int ord[$];
    int slot;
    longint prev_end, gap, s, e, limit, best_gap, best_addr, nxt;
    bit found;
    outcome_t o;
    slot = -1;
    found = 0;
    prev_end = 0;
    best_gap = 0;
    best_addr = 0;
    nxt = 0;
    case (cmd)
      CMD_ALLOC: begin
        for (int i = 0; i < MAX_SEGMENTS; i++)
          if (slot < 0 && !table_q[i].used) slot = i;
        if (len == 0) awaited_q.push_back(plain(ST_NOSPACE, 0));
        else if (slot < 0) awaited_q.push_back(plain(ST_FULL, 0));
        else begin
          order_by_start(ord);
          limit = (mem_size > (1 << ADDR_BITS)) ? (1 << ADDR_BITS) : mem_size;
          for (int i = 0; i <= ord.size(); i++) begin
            if (i < ord.size()) begin
              s = table_q[ord[i]].start;
              e = s + table_q[ord[i]].length;
            end else begin
              s = limit;
              e = limit;
            end
            gap = (s > prev_end) ? s - prev_end : 0;
            if (gap >= len && (!found || (best_fit && gap < best_gap))) begin
              found = 1;
              best_gap = gap;
              best_addr = prev_end;
              if (!best_fit) break;
            end
            if (e > prev_end) prev_end = e;
          end
          if (!found) awaited_q.push_back(plain(ST_NOSPACE, 0));
          else begin
            table_q[slot] = '{1'b1, best_addr[ADDR_BITS-1:0], len, kind, id};
            awaited_q.push_back(plain(ST_OK, best_addr[ADDR_BITS-1:0]));
          end
        end
      end
      CMD_RELEASE: begin
        for (int i = 0; i < MAX_SEGMENTS; i++)
          if (slot < 0 && table_q[i].used && table_q[i].kind == kind
              && table_q[i].owner == id) slot = i;
        if (slot >= 0) begin
          table_q[slot].used = 0;
          awaited_q.push_back(plain(ST_OK, 0));
        end else awaited_q.push_back(plain(ST_NOTFOUND, 0));
      end
      CMD_COMPACT: begin
        order_by_start(ord);
        foreach (ord[i]) begin
          o.status       = ST_MOVE;
          o.address      = nxt[ADDR_BITS-1:0];
          o.old_address  = table_q[ord[i]].start;
          o.moved_length = table_q[ord[i]].length;
          o.moved_kind   = table_q[ord[i]].kind;
          o.moved_id     = table_q[ord[i]].owner;
          o.last         = (i == ord.size() - 1);
          table_q[ord[i]].start = o.address;
          nxt = o.address + o.moved_length;
          awaited_q.push_back(o);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic compare_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t w;
    logic [OUT_DATA_W-1:0] d;
    if (!rst_ni) begin
      foreach (table_q[i]) table_q[i].used = 0;
      mem_size  = MEM_SIZE_RESET;
      best_fit  = 0;
      awaited_q = {};
      errors_o  = 0;
      results_o = 0;
      moves_o   = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_MEMORY_SIZE) mem_size = cfg_data_i;
        else best_fit = cfg_data_i[0];
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        results_o++;
        if (m_axis_tuser_i == ST_MOVE) moves_o++;
        if (awaited_q.size() == 0) begin
          $error("result transaction with no expectation waiting");
          errors_o++;
        end else begin
          w = awaited_q.pop_front();
          d = m_axis_tdata_i;
          compare_field("status", w.status, m_axis_tuser_i);
          compare_field("address", w.address, d[19:0]);
          compare_field("old_address", w.old_address, d[39:20]);
          compare_field("moved_length", w.moved_length, d[60:40]);
          compare_field("moved_kind", w.moved_kind, d[62:61]);
          compare_field("moved_id", w.moved_id, d[78:63]);
          compare_field("last", w.last, m_axis_tlast_i);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        predict_command(s_axis_tuser_i, s_axis_tdata_i[1:0], s_axis_tdata_i[17:2],
                        s_axis_tdata_i[38:18]);
    end
  end

endmodule

@@ sim/segment_placement_allocator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment placement allocator testbench
// Drives directed and random allocate, release and compact commands under
// several memory sizes, both fit rules and varied stream back-pressure; the
// checker judges every result transaction.
// ----------------------------------------------------------------------------
module segment_placement_allocator_tb;
  import spa_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_valid = 0, s_ready, m_valid, m_ready = 0, m_last;
  logic [IN_DATA_W-1:0] s_data = '0;
  logic [CMD_W-1:0] s_user = CMD_NONE;
  logic [OUT_DATA_W-1:0] m_data;
  logic [STAT_W-1:0] m_user;
  logic cfg_we = 0, cfg_idx = 0;
  logic [LEN_W-1:0] cfg_data = '0;
  int errors, pending, results, moves;
  int send_idle = 0, recv_stall = 0, quiet = 0;
  bit timed_out = 0;
  bit [ID_W-1:0] ids[$];
  bit [KIND_W-1:0] kinds[$];

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  segment_placement_allocator dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tuser_o(m_user), .m_axis_tlast_o(m_last),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  segment_placement_allocator_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_i(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user),
    .m_axis_tvalid_i(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_i(m_data), .m_axis_tuser_i(m_user), .m_axis_tlast_i(m_last),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending), .results_o(results), .moves_o(moves)
  );

  always @(negedge clk_i) m_ready <= ($urandom_range(99) >= recv_stall);

  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000 && !timed_out) begin
      timed_out = 1;
      $display("segment_placement_allocator test failed");
      $finish;
    end
  end

  task automatic send(cmd_e cmd, bit [KIND_W-1:0] kind, bit [ID_W-1:0] id,
                      bit [LEN_W-1:0] len);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) @(negedge clk_i);
    s_valid <= 1;
    s_user  <= cmd;
    s_data  <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, len, id, kind};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    @(negedge clk_i);
    s_valid <= 0;
    if (cmd == CMD_ALLOC && len != 0) begin
      ids.push_back(id);
      kinds.push_back(kind);
    end
  endtask

  task automatic settle();
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, bit [LEN_W-1:0] val);
    settle();
    @(negedge clk_i);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 0;
  endtask

  // Mostly well-formed traffic: allocates of small lengths, releases of
  // known segments, occasional compacts and rare junk.
  task automatic random_phase(int n);
    int r, k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45) send(CMD_ALLOC, KIND_W'($urandom_range(2)), ID_W'($urandom),
                       ($urandom_range(9) == 0) ? LEN_W'($urandom)
                                                : LEN_W'($urandom_range(1, 300)));
      else if (r < 80 && ids.size() > 0) begin
        k = $urandom_range(ids.size() - 1);
        send(CMD_RELEASE, kinds[k], ids[k], LEN_W'($urandom));
        ids.delete(k);
        kinds.delete(k);
      end else if (r < 88) send(CMD_COMPACT, KIND_W'($urandom), ID_W'($urandom),
                                LEN_W'($urandom));
      else if (r < 95) send(CMD_RELEASE, KIND_W'($urandom), ID_W'($urandom),
                            LEN_W'($urandom));
      else send(CMD_NONE, KIND_W'($urandom), ID_W'($urandom), LEN_W'($urandom));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    send(CMD_ALLOC, 0, 16'h0000, 0);
    send(CMD_ALLOC, 2, 16'hFFFF, 21'h1FFFFF);
    send(CMD_ALLOC, 1, 16'h0001, 100);
    send(CMD_ALLOC, 2, 16'h0002, 200);
    send(CMD_ALLOC, 0, 16'h0003, 50);
    send(CMD_RELEASE, 1, 16'h0001, 0);
    send(CMD_RELEASE, 1, 16'h0001, 0);
    send(CMD_ALLOC, 1, 16'h0004, 100);
    send(CMD_RELEASE, 2, 16'h0002, 0);
    send(CMD_ALLOC, 1, 16'h0004, 60);
    send(CMD_NONE, 3, 16'hFFFF, 21'h1FFFFF);
    send(CMD_COMPACT, 0, 0, 0);
    for (int i = 0; i < 34; i++) send(CMD_ALLOC, KIND_W'(i % 3), 16'(i + 100), 1);
    send(CMD_COMPACT, 0, 0, 0);
    for (int i = 0; i < 32; i++) send(CMD_RELEASE, 0, 0, 0);
    ids = {};
    kinds = {};
    for (int i = 0; i < 32; i++) send(CMD_RELEASE, 0, 0, 0);
    send(CMD_COMPACT, 0, 0, 0);

    write_reg(REG_MEMORY_SIZE, 21'h100000);
    write_reg(REG_FIT_MODE, LEN_W'(FIT_BF));
    send(CMD_ALLOC, 3, 16'hAAAA, 21'h100000);
    send(CMD_ALLOC, 1, 16'h5555, 10);
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1 || ph == 3) ? ((ph == 3) ? 21 : 57) : 0;
      recv_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 21 : 57) : 0;
      write_reg(REG_FIT_MODE, LEN_W'(ph[0]));
      write_reg(REG_MEMORY_SIZE,
                (ph == 2) ? 21'd1 : ((ph == 3) ? 21'h1FFFFF : LEN_W'(1500)));
      random_phase(54);
      settle();
    end
    send_idle = 0;
    recv_stall = 0;

    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Covered %0d result transactions, %0d of them move records,", results, moves);
    $display("across both fit rules and memory sizes from 1 byte to the full range.");
    if (errors == 0) $display("segment_placement_allocator test passed");
    else $display("segment_placement_allocator test failed");
    $finish;
  end

endmodule

@@ segment_placement_allocator.f @@
src/spa_pkg.sv
src/spa_cell.sv
src/segment_placement_allocator.sv
sim/segment_placement_allocator_checker.sv
sim/segment_placement_allocator_tb.sv
